// ----- rtl/iso_pkg.sv -----
// shared types and constants for the iso8601 timestamp to epoch milliseconds converter
package iso_pkg;

   // one parsed timestamp, handed from the byte parser to the date arithmetic
   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [9:0]  fraction;
      logic        ok;
   } iso_rec_type;

   // record queue between parser and arithmetic
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // arithmetic chain length from captured record to finished milliseconds
   localparam int CalcSteps = 8;
   localparam int CalcStepW = $clog2(CalcSteps);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CALC,
      BK_HOLD
   } bk_state_type;

endpackage

// ----- rtl/iso_front.sv -----
// byte parser: gathers the decimal fields and the fraction, emits one record per text
module iso_front import iso_pkg::*; #(
   parameter int FRACTION_DIGITS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   input  logic        q_full,
   output logic        q_push,
   output iso_rec_type q_rec
);

   localparam logic [4:0] YearEnd   = 5'd3;
   localparam logic [4:0] MonthEnd  = 5'd6;
   localparam logic [4:0] DayEnd    = 5'd9;
   localparam logic [4:0] HourEnd   = 5'd12;
   localparam logic [4:0] MinuteEnd = 5'd15;
   localparam logic [4:0] FieldEnd  = 5'd18;
   localparam logic [4:0] DotPos    = 5'd19;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [1:0] FracLimit = 2'(FRACTION_DIGITS);

   function automatic logic [6:0] frac_weight(input logic [1:0] idx);
      logic [6:0] w;
      case (idx)
         2'd0:    w = 7'd100;
         2'd1:    w = 7'd10;
         default: w = 7'd1;
      endcase
      return w;
   endfunction

   logic [4:0]  pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        err_ff, err_in;
   logic [9:0]  frac_ff, frac_in;
   logic [1:0]  fcnt_ff, fcnt_in;
   logic        fact_ff, fact_in;

   logic       accept;
   logic       is_digit;
   logic [3:0] digit;
   logic       is_sep;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_digit  = (req_char_code >= CharZero) && (req_char_code <= CharNine);
   assign digit     = is_digit ? 4'(req_char_code - CharZero) : 4'd0;
   assign is_sep    = (pos_ff == YearEnd + 5'd1) || (pos_ff == MonthEnd + 5'd1) ||
                      (pos_ff == DayEnd + 5'd1) || (pos_ff == HourEnd + 5'd1) ||
                      (pos_ff == MinuteEnd + 5'd1);

   always_comb begin
      pos_in    = pos_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      err_in    = err_ff;
      frac_in   = frac_ff;
      fcnt_in   = fcnt_ff;
      fact_in   = fact_ff;

      if (pos_ff <= FieldEnd && !is_sep) begin
         if (!is_digit) begin
            err_in = 1'b1;
         end else if (pos_ff <= YearEnd) begin
            year_in = 14'(year_ff * 14'd10 + 14'(digit));
         end else if (pos_ff <= MonthEnd) begin
            month_in = 7'(month_ff * 7'd10 + 7'(digit));
         end else if (pos_ff <= DayEnd) begin
            day_in = 7'(day_ff * 7'd10 + 7'(digit));
         end else if (pos_ff <= HourEnd) begin
            hour_in = 7'(hour_ff * 7'd10 + 7'(digit));
         end else if (pos_ff <= MinuteEnd) begin
            minute_in = 7'(minute_ff * 7'd10 + 7'(digit));
         end else begin
            second_in = 7'(second_ff * 7'd10 + 7'(digit));
         end
      end else if (pos_ff == DotPos) begin
         fact_in = (req_char_code == CharDot);
      end else if (pos_ff > DotPos && fact_ff) begin
         if (fcnt_ff >= FracLimit || !is_digit) begin
            fact_in = 1'b0;
         end else begin
            frac_in = 10'(frac_ff + 10'(digit) * 10'(frac_weight(fcnt_ff)));
            fcnt_in = 2'(fcnt_ff + 2'd1);
         end
      end

      if (!(&pos_ff)) begin
         pos_in = 5'(pos_ff + 5'd1);
      end
   end

   always_comb begin
      q_push          = accept && req_last_char;
      q_rec.year      = year_in;
      q_rec.month     = month_in;
      q_rec.day       = day_in;
      q_rec.hour      = hour_in;
      q_rec.minute    = minute_in;
      q_rec.second    = second_in;
      q_rec.fraction  = frac_in;
      q_rec.ok        = (pos_ff >= FieldEnd) && !err_in && (month_in != 7'd0) &&
                        (day_in != 7'd0);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_char)) begin
         pos_ff    <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         err_ff    <= 1'b0;
         frac_ff   <= '0;
         fcnt_ff   <= '0;
         fact_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         err_ff    <= err_in;
         frac_ff   <= frac_in;
         fcnt_ff   <= fcnt_in;
         fact_ff   <= fact_in;
      end
   end

endmodule

// ----- rtl/iso_queue.sv -----
// short record queue between the byte parser and the date arithmetic
module iso_queue import iso_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  iso_rec_type push_rec,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output iso_rec_type head_rec
);

   iso_rec_type          mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 :
                     QueuePtrW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 :
                     QueuePtrW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = QueueCntW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QueueCntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ----- rtl/iso_back.sv -----
// date arithmetic: days-from-civil and milliseconds chain, result register
module iso_back import iso_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  iso_rec_type        q_rec,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [48:0] rsp_epoch_millis,
   output logic               rsp_parse_ok
);

   function automatic logic [1:0] div100(input logic [8:0] v);
      logic [1:0] q;
      if (v >= 9'd300) begin
         q = 2'd3;
      end else if (v >= 9'd200) begin
         q = 2'd2;
      end else if (v >= 9'd100) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

   bk_state_type         state_ff, state_in;
   logic [CalcStepW-1:0] step_ff, step_in;
   iso_rec_type          rec_ff;
   logic                 load;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [48:0]   epoch_ff;
   logic                 ok_ff;

   // arithmetic chain registers
   logic signed [14:0] y1_ff;
   logic [6:0]         mp1_ff;
   logic [16:0]        secp1_ff;
   logic signed [5:0]  era2_ff;
   logic [14:0]        mpx2_ff;
   logic signed [14:0] y2_ff;
   logic [16:0]        secp2_ff;
   logic [8:0]         yoe3_ff;
   logic [11:0]        doy3_ff;
   logic signed [5:0]  era3_ff;
   logic [16:0]        secp3_ff;
   logic [17:0]        doe4_ff;
   logic signed [22:0] eraday4_ff;
   logic [16:0]        secp4_ff;
   logic signed [22:0] days5_ff;
   logic [16:0]        secp5_ff;
   logic signed [27:0] hrs6_ff;
   logic [16:0]        secp6_ff;
   logic signed [32:0] mins7_ff;
   logic [16:0]        secp7_ff;
   logic signed [48:0] ms8_ff;

   logic [26:0]        era_prod;
   logic [30:0]        doy_prod;
   logic signed [15:0] era400;
   logic signed [15:0] yoe_diff;
   logic signed [22:0] era_ext;

   assign era_prod = 27'(y1_ff[13:0]) * 27'd5243;
   assign doy_prod = 31'(mpx2_ff) * 31'd52429;
   assign era400   = {{10{era2_ff[5]}}, era2_ff} * 16'sd400;
   assign yoe_diff = {y2_ff[14], y2_ff} - era400;
   assign era_ext  = {{17{era3_ff[5]}}, era3_ff};

   always_ff @(posedge clock) begin
      // year shift for jan and feb, month index from march
      y1_ff    <= (rec_ff.month <= 7'd2) ? $signed({1'b0, rec_ff.year}) - 15'sd1 :
                  $signed({1'b0, rec_ff.year});
      mp1_ff   <= (rec_ff.month <= 7'd2) ? 7'(rec_ff.month + 7'd9) :
                  7'(rec_ff.month - 7'd3);
      secp1_ff <= 17'(17'(rec_ff.second) * 17'd1000 + 17'(rec_ff.fraction));
      // floor division of the shifted year by 400
      era2_ff  <= y1_ff[14] ? -6'sd1 : $signed({1'b0, era_prod[25:21]});
      mpx2_ff  <= 15'(15'(mp1_ff) * 15'd153 + 15'd2);
      y2_ff    <= y1_ff;
      secp2_ff <= secp1_ff;
      // year of era and day of year
      yoe3_ff  <= yoe_diff[8:0];
      doy3_ff  <= 12'(doy_prod[29:18] + 12'(rec_ff.day) - 12'd1);
      era3_ff  <= era2_ff;
      secp3_ff <= secp2_ff;
      // day of era and era offset
      doe4_ff    <= 18'(18'(yoe3_ff) * 18'd365 + 18'(yoe3_ff[8:2]) -
                       18'(div100(yoe3_ff)) + 18'(doy3_ff));
      eraday4_ff <= era_ext * 23'sd146097;
      secp4_ff   <= secp3_ff;
      days5_ff   <= eraday4_ff + $signed({5'b0, doe4_ff}) - 23'sd719468;
      secp5_ff   <= secp4_ff;
      hrs6_ff    <= {{5{days5_ff[22]}}, days5_ff} * 28'sd24 +
                    $signed({21'b0, rec_ff.hour});
      secp6_ff   <= secp5_ff;
      mins7_ff   <= {{5{hrs6_ff[27]}}, hrs6_ff} * 33'sd60 +
                    $signed({26'b0, rec_ff.minute});
      secp7_ff   <= secp6_ff;
      ms8_ff     <= {{16{mins7_ff[32]}}, mins7_ff} * 49'sd60000 +
                    $signed({32'b0, secp7_ff});
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               step_in  = CalcStepW'(CalcSteps - 1);
               state_in = BK_CALC;
            end
         end
         BK_CALC: begin
            if (step_ff == '0) begin
               state_in = BK_HOLD;
            end else begin
               step_in = CalcStepW'(step_ff - 1'b1);
            end
         end
         BK_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff <= q_rec;
      end
      if (load) begin
         epoch_ff <= rec_ff.ok ? ms8_ff : '0;
         ok_ff    <= rec_ff.ok;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_epoch_millis = epoch_ff;
   assign rsp_parse_ok     = ok_ff;

`ifndef SYNTH
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> epoch_ff == '0)
      else $error("failed parse delivered a nonzero value");

   a_pop_starts_calc: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == BK_CALC && step_ff == CalcStepW'(CalcSteps - 1))
      else $error("record capture did not start the arithmetic chain");

   a_rec_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_CALC && $past(state_ff) == BK_CALC |-> $stable(rec_ff))
      else $error("record changed during arithmetic");

   a_load_after_calc: assert property (@(posedge clock) disable iff (reset)
      load |-> $past(state_ff) == BK_CALC || $past(state_ff) == BK_HOLD)
      else $error("result loaded without a finished computation");

   a_jan_feb_shift: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_rec.month <= 7'd2 |=> rec_ff.month <= 7'd2)
      else $error("captured record differs from queue head");
`endif

endmodule

// ----- rtl/iso8601_to_epoch_millis.sv -----
// top level of the iso8601 timestamp to unix epoch milliseconds converter
//
// req channel: one text byte per transfer (req_char_code), req_last_char marks
//   the final byte of a timestamp YYYY-MM-DDTHH:MM:SS[.fff]
// rsp channel: one transfer per marked byte with signed milliseconds since
//   1970-01-01 utc in rsp_epoch_millis and rsp_parse_ok; a short text, a
//   non-digit in a date or time field, or a zero month or day gives 0 and
//   rsp_parse_ok low
// the parser takes one byte per cycle while the queue has room; each finished
//   text becomes a record in a two-entry queue
// result path, queue empty: the queue write shares the edge of the transfer
//   of the last byte, followed by capture, the 8-step arithmetic chain and the
//   result register
// throughput: one byte per cycle while the queue has room; the arithmetic unit
//   takes one record at a time, from capture through the result register
// rsp_stall holds the result register; the arithmetic unit keeps its record,
//   the queue fills, and req_stall rises only when the queue is full
// reset clears parser state, queue and result valid; no transfer is pending
module iso8601_to_epoch_millis import iso_pkg::*; #(
   parameter int FRACTION_DIGITS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [48:0] rsp_epoch_millis,
   output logic               rsp_parse_ok
);

   // parser to queue
   logic        q_full;
   logic        q_push;
   iso_rec_type q_push_rec;

   // queue to arithmetic
   logic        q_pop;
   logic        q_head_valid;
   iso_rec_type q_head_rec;

   iso_front #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_rec         (q_push_rec)
   );

   iso_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_push_rec),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_rec   (q_head_rec)
   );

   // days-from-civil and milliseconds chain
   iso_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_head_valid),
      .q_rec            (q_head_rec),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_epoch_millis (rsp_epoch_millis),
      .rsp_parse_ok     (rsp_parse_ok)
   );

endmodule
